@@ hdl/rsp_pkg.sv @@
`default_nettype none

package rsp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W = 6;
  localparam int unsigned RESET_LEN = 10;

  // low byte of the field polynomial 0x11d
  localparam logic [BYTE_W-1:0] POLY_LOW = 8'h1d;

  // cell operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_GEN   = 2'd2;
  localparam logic [1:0] OP_SHIFT = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] fb;
    logic [BYTE_W-1:0] root;
  } ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
    gf_xtime = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? POLY_LOW : '0);
  endfunction

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      acc = gf_xtime(acc);
      if (b[k]) begin
        acc = acc ^ a;
      end
    end
    gf_mul = acc;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rsp_cell.sv @@
`default_nettype none

module rsp_cell (
  input  wire logic                       clk,
  input  wire rsp_pkg::ctrl_t             ctrl,
  input  wire logic                       tail,
  input  wire logic [rsp_pkg::BYTE_W-1:0] rem_in,
  input  wire logic [rsp_pkg::BYTE_W-1:0] g_in,
  output logic      [rsp_pkg::BYTE_W-1:0] rem_q,
  output logic      [rsp_pkg::BYTE_W-1:0] g_q
);

  logic [rsp_pkg::BYTE_W-1:0] rem_r;
  logic [rsp_pkg::BYTE_W-1:0] rem_nxt;
  logic [rsp_pkg::BYTE_W-1:0] g_r;
  logic [rsp_pkg::BYTE_W-1:0] g_nxt;
  logic [rsp_pkg::BYTE_W-1:0] rem_nb;
  logic [rsp_pkg::BYTE_W-1:0] g_nb;
  logic [rsp_pkg::BYTE_W-1:0] mul_b;
  logic [rsp_pkg::BYTE_W-1:0] prod;

  // the tail cell sees zero from beyond the active chain
  assign rem_nb = tail ? '0 : rem_in;
  assign g_nb   = tail ? '0 : g_in;

  // one multiplier, shared between generator setup and byte absorption
  assign mul_b = (ctrl.op == rsp_pkg::OP_GEN) ? ctrl.root : ctrl.fb;
  assign prod  = rsp_pkg::gf_mul(g_r, mul_b);

  always_comb begin
    rem_nxt = rem_r;
    g_nxt   = g_r;
    unique case (ctrl.op)
      rsp_pkg::OP_HOLD: begin
      end
      rsp_pkg::OP_INIT: begin
        rem_nxt = '0;
        g_nxt   = tail ? rsp_pkg::BYTE_W'(1) : '0;
      end
      rsp_pkg::OP_GEN: begin
        g_nxt = prod ^ g_nb;
      end
      rsp_pkg::OP_SHIFT: begin
        rem_nxt = rem_nb ^ prod;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    g_r   <= g_nxt;
  end

  assign rem_q = rem_r;
  assign g_q   = g_r;

endmodule

`default_nettype wire

@@ hdl/reed_solomon_parity_encoder.sv @@
// a data byte is absorbed whenever in_valid is high and in_stall is low; the first parity byte is shown the cycle
// after the byte marked block end, then one parity byte per cycle while out_stall is low
// input is stalled until the last parity byte is taken, since the single remainder chain shifts them out
// reset and every parity_length write start a setup pass that builds the generator in the cells
// and clears the remainder; input is stalled during it
// reset (rst_n low, synchronous) sets parity length 10, or MAX_PARITY if that is smaller
`default_nettype none

module reed_solomon_parity_encoder #(
  parameter int unsigned MAX_PARITY = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [rsp_pkg::CFG_W-1:0]  cfg_parity_length,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rsp_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                       in_block_end,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [rsp_pkg::BYTE_W-1:0] out_parity_byte,
  output logic                            out_parity_last
);

  localparam int unsigned LW = $clog2(MAX_PARITY + 1);
  localparam int unsigned CW = (LW > rsp_pkg::CFG_W) ? LW : rsp_pkg::CFG_W;
  localparam int unsigned RST_LEN =
    (MAX_PARITY < rsp_pkg::RESET_LEN) ? MAX_PARITY : rsp_pkg::RESET_LEN;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_r;
  logic [1:0]                  state_nxt;
  logic [LW-1:0]               len_r;
  logic [LW-1:0]               len_nxt;
  logic [LW-1:0]               cnt_r;
  logic [LW-1:0]               cnt_nxt;
  logic [rsp_pkg::BYTE_W-1:0]  root_r;
  logic [rsp_pkg::BYTE_W-1:0]  root_nxt;
  logic [CW-1:0]               cfg_ext;
  logic [LW-1:0]               cfg_len;
  logic [LW-1:0]               last_idx;
  logic                        cnt_done;
  logic                        in_xfer;
  rsp_pkg::ctrl_t              ctrl;

  logic [rsp_pkg::BYTE_W-1:0]  rem_q [MAX_PARITY];
  logic [rsp_pkg::BYTE_W-1:0]  g_q   [MAX_PARITY];

  // clamp the written length into 1..MAX_PARITY
  always_comb begin
    cfg_ext = CW'(cfg_parity_length);
    priority if (cfg_ext == '0) begin
      cfg_len = LW'(1);
    end else if (cfg_ext > CW'(MAX_PARITY)) begin
      cfg_len = LW'(MAX_PARITY);
    end else begin
      cfg_len = LW'(cfg_ext);
    end
  end

  assign last_idx = len_r - LW'(1);
  assign cnt_done = (cnt_r == last_idx);

  assign in_stall        = (state_r != ST_RUN) || cfg_wr_en;
  assign in_xfer         = in_valid && !in_stall;
  assign out_valid       = (state_r == ST_EMIT);
  assign out_parity_byte = rem_q[0];
  assign out_parity_last = cnt_done;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    root_nxt  = root_r;
    ctrl.op   = rsp_pkg::OP_HOLD;
    ctrl.fb   = '0;
    ctrl.root = root_r;
    unique case (state_r)
      ST_INIT: begin
        ctrl.op   = rsp_pkg::OP_INIT;
        cnt_nxt   = '0;
        root_nxt  = rsp_pkg::BYTE_W'(1);
        state_nxt = ST_GEN;
      end
      ST_GEN: begin
        // one generator factor (x + root) per cycle
        ctrl.op  = rsp_pkg::OP_GEN;
        root_nxt = rsp_pkg::gf_xtime(root_r);
        cnt_nxt  = cnt_r + LW'(1);
        if (cnt_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_xfer) begin
          ctrl.op = rsp_pkg::OP_SHIFT;
          ctrl.fb = in_data_byte ^ rem_q[0];
          if (in_block_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // zero feedback turns the chain into a plain shift that drains to zero
        if (!out_stall) begin
          ctrl.op = rsp_pkg::OP_SHIFT;
          cnt_nxt = cnt_r + LW'(1);
          if (cnt_done) begin
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
    endcase
    if (cfg_wr_en) begin
      len_nxt   = cfg_len;
      state_nxt = ST_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      len_r   <= LW'(RST_LEN);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
  end

  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    logic [rsp_pkg::BYTE_W-1:0] rem_in;
    logic [rsp_pkg::BYTE_W-1:0] g_in;
    logic                       tail;

    if (i < MAX_PARITY - 1) begin : g_link
      assign rem_in = rem_q[i+1];
      assign g_in   = g_q[i+1];
    end else begin : g_end
      assign rem_in = '0;
      assign g_in   = '0;
    end

    assign tail = (LW'(i) == last_idx);

    rsp_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .tail   (tail),
      .rem_in (rem_in),
      .g_in   (g_in),
      .rem_q  (rem_q[i]),
      .g_q    (g_q[i])
    );
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_PARITY = 32;
  localparam int unsigned SETTLE_CYCLES = MAX_PARITY + 4;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam longint unsigned RUN_LIMIT_NS = 64'd8_000_000;

  // x^8 + x^4 + x^3 + x^2 + 1 with the x^8 term dropped
  localparam logic [7:0] POLY_TAIL = 8'h1d;
  localparam logic [7:0] ROOT_STEP = 8'h02;

  typedef logic [rsp_pkg::BYTE_W-1:0] gf_t;
  typedef logic [rsp_pkg::CFG_W-1:0] len_t;

  typedef struct packed {
    gf_t  value;
    logic last;
  } parity_t;

  class parity_scoreboard;
    gf_t taps[MAX_PARITY];
    gf_t remainder[MAX_PARITY];
    int unsigned depth;
    parity_t expected_parity[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned blocks_seen;
    int unsigned parity_seen;

    function new();
      errors = 0;
      bytes_seen = 0;
      blocks_seen = 0;
      parity_seen = 0;
      set_length(len_t'(rsp_pkg::RESET_LEN));
    endfunction

    function gf_t gf_times(gf_t a, gf_t b);
      gf_t x;
      gf_t y;
      gf_t acc;
      x = a;
      y = b;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
        if (y[0]) acc = acc ^ x;
        x = {x[6:0], 1'b0} ^ (x[7] ? POLY_TAIL : 8'h00);
        y = y >> 1;
      end
      return acc;
    endfunction

    // rebuild the generator as the product of (x + 2^i) and start a fresh block
    function void set_length(len_t v);
      gf_t poly[MAX_PARITY+1];
      gf_t r;
      if (v == 0) depth = 1;
      else if (v > MAX_PARITY) depth = MAX_PARITY;
      else depth = v;
      foreach (poly[k]) poly[k] = '0;
      poly[0] = 8'h01;
      r = 8'h01;
      for (int i = 0; i < depth; i++) begin
        for (int k = i + 1; k > 0; k--) poly[k] = poly[k-1] ^ gf_times(poly[k], r);
        poly[0] = gf_times(poly[0], r);
        r = gf_times(r, ROOT_STEP);
      end
      // taps hold the coefficients below the leading one, highest power first
      for (int j = 0; j < MAX_PARITY; j++) begin
        if (j < depth) taps[j] = poly[depth-1-j];
        else taps[j] = '0;
        remainder[j] = '0;
      end
    endfunction

    function void note_byte(gf_t d, logic end_flag);
      gf_t fb;
      parity_t p;
      fb = d ^ remainder[0];
      for (int i = 0; i < depth; i++) begin
        if (i + 1 < depth) remainder[i] = remainder[i+1] ^ gf_times(taps[i], fb);
        else remainder[i] = gf_times(taps[i], fb);
      end
      bytes_seen++;
      if (end_flag) begin
        blocks_seen++;
        for (int i = 0; i < depth; i++) begin
          p.value = remainder[i];
          p.last = (i + 1 == depth);
          expected_parity = {expected_parity, p};
        end
        foreach (remainder[i]) remainder[i] = '0;
      end
    endfunction

    function void check_parity(gf_t got, logic got_last);
      parity_t want;
      parity_seen++;
      if (expected_parity.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: expected no parity byte, got byte %02h last %0b",
                   $time, got, got_last);
      end else begin
        want = expected_parity.pop_front();
        if (want.value !== got || want.last !== got_last) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: expected byte %02h last %0b, got byte %02h last %0b",
                     $time, want.value, want.last, got, got_last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_parity.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  len_t cfg_parity_length;
  logic in_valid;
  logic in_stall;
  gf_t  in_data_byte;
  logic in_block_end;
  logic out_valid;
  logic out_stall;
  gf_t  out_parity_byte;
  logic out_parity_last;

  bit hold_request = 1'b0;
  bit no_idle = 1'b0;
  int unsigned settings_written = 0;

  parity_scoreboard sb = new();

  reed_solomon_parity_encoder #(
    .MAX_PARITY(MAX_PARITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_parity_length(cfg_parity_length),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_block_end(in_block_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_parity_byte(out_parity_byte),
    .out_parity_last(out_parity_last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // results are checked before the same edge's input is absorbed
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_parity(out_parity_byte, out_parity_last);
      if (in_valid && !in_stall) sb.note_byte(in_data_byte, in_block_end);
    end
  end

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic gf_t random_data();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return gf_t'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly short parity runs, now and then long ones and clamped values
  function automatic len_t pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return len_t'($urandom_range(1, 8));
    if (r < 9) return len_t'($urandom_range(9, 32));
    return len_t'($urandom_range(33, 63));
  endfunction

  // receiver: go stretches, short and long stalls, and one long hold-off on request
  initial begin
    int unsigned go;
    int unsigned hold;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        go = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        hold = no_idle ? 0 : random_gap();
        out_stall <= 1'b0;
        repeat (go) @(posedge clk);
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  task automatic send_byte(input gf_t d, input logic end_flag);
    int unsigned g;
    g = no_idle ? 0 : random_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_block_end <= end_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // always waits for a clock edge before reading the queue, so the last transaction is noted first
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_length(input len_t v);
    drain();
    // a non-final byte leaves nothing to wait on, so let the block settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_parity_length <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_length(v);
    settings_written++;
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_items;
    int unsigned size;
    bit paused;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_parity_length <= '0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_block_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset length, byte extremes, mid-block write, clamped lengths
    no_idle = 1'b1;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b0);
    send_byte(8'h37, 1'b0);
    // write lands mid-block, so the half-built remainder is thrown away
    write_length(len_t'(1));
    send_byte(8'h12, 1'b0);
    send_byte(8'hfe, 1'b1);
    write_length(len_t'(0));
    send_byte(8'hff, 1'b1);
    write_length(len_t'(32));
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b1);
    write_length(len_t'(63));
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    no_idle = 1'b0;

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 2) write_length(len_t'(16));
      else write_length(pick_length());
      no_idle = (phase % 3 == 2);
      // receiver holds off while the sender keeps offering, so input backs up
      if (phase == 2) hold_request = 1'b1;
      phase_items = 0;
      paused = 1'b0;
      while (phase_items < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
        size = $urandom_range(1, 6);
        for (int i = 0; i < size; i++) send_byte(random_data(), i == size - 1);
        phase_items += size;
        sent += size;
        if (phase == 1 && !paused) begin
          drain();
          paused = 1'b1;
        end
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d data bytes in %0d blocks over %0d length writes",
             sb.bytes_seen, sb.blocks_seen, settings_written);
    $display("checked %0d parity bytes, %0d mismatches", sb.parity_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending() != 0) $display("%0d parity bytes never arrived", sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timed out with %0d parity bytes outstanding", sb.pending());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rsp_pkg.sv
hdl/rsp_cell.sv
hdl/reed_solomon_parity_encoder.sv
bench/testbench.sv
